FILE: hdl/slq_pkg.sv
// Package for the sorted list queue: request and status codes, widths, cell control.
package slq_pkg;

  // Payload widths
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OCC_W     = 5;

  // Default number of cells
  localparam int unsigned DEPTH_DEF = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP_MIN   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_MAX   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_MATCH = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  // Move command broadcast to every cell
  typedef struct packed {
    logic insert;     // open a slot at the insert point, shift the rest right
    logic pop_min;    // every cell takes its right neighbor
    logic del_match;  // cells at or above the key take their right neighbor
  } cell_ctl_t;

endpackage

FILE: hdl/slq_if.sv
// Request and response channel interfaces of the sorted list queue.
interface slq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [slq_pkg::REQ_W-1:0]            req_type;
  logic signed [slq_pkg::VALUE_W-1:0]   item_value;

  modport source (output valid, req_type, item_value, input ready);
  modport sink   (input valid, req_type, item_value, output ready);
endinterface

interface slq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [slq_pkg::STATUS_W-1:0]         status;
  logic signed [slq_pkg::VALUE_W-1:0]   removed_value;
  logic [slq_pkg::OCC_W-1:0]            occupancy;

  modport source (output valid, status, removed_value, occupancy, input ready);
  modport sink   (input valid, status, removed_value, occupancy, output ready);
endinterface

FILE: hdl/sorted_list_queue.sv
// Top level of the sorted list queue: a chain of cells with a registered response.
//
// Usage:
//   in_req  carries one request word: req_type (insert, pop smallest, pop
//           largest, delete matching value, clear) and item_value.
//   out_rsp returns exactly one word per request: status, removed_value
//           (zero when nothing leaves) and occupancy after the request.
//   Values are held in ascending signed order in DEPTH cells. Every cell
//   compares against the request value at once, so the insert point or the
//   match is found in the same cycle and each cell then takes its own value,
//   the key, or its left or its right neighbor's.
//   The response is registered and appears in the cycle after the request is accepted.
//   Throughput: one request per cycle while out_rsp is ready, set by the single
//   response register; in_req.ready is high when it is empty or being drained.
//   Reset empties the queue (fill level zero) and drops a pending response;
//   cell contents are not cleared, as only slots below the fill level count.
//   When out_rsp stalls, the response holds and in_req.ready drops until it
//   is taken.
module sorted_list_queue #(
  parameter int unsigned DEPTH = slq_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  slq_req_if.sink   in_req,
  slq_rsp_if.source out_rsp
);

  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned VW     = slq_pkg::VALUE_W;

  logic [FILL_W-1:0]    fill_r;
  logic [FILL_W-1:0]    fill_nxt;
  logic                 out_valid_r;
  logic [slq_pkg::STATUS_W-1:0] status_r;
  logic [slq_pkg::STATUS_W-1:0] status_nxt;
  logic signed [VW-1:0] removed_r;
  logic signed [VW-1:0] removed_nxt;
  logic [slq_pkg::OCC_W-1:0] occ_r;

  slq_pkg::cell_ctl_t   ctl;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 match_any;
  logic signed [VW-1:0] tail_value;

  logic signed [VW-1:0] cell_value [DEPTH];
  logic signed [VW-1:0] tail_pick  [DEPTH];
  logic [DEPTH-1:0]     ge_vec;
  logic [DEPTH-1:0]     eq_vec;

  assign accept       = in_req.valid && in_req.ready;
  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign full         = (fill_r == FILL_W'(DEPTH));
  assign empty        = (fill_r == '0);
  assign match_any    = |eq_vec;

  // chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VW-1:0] left_v;
    logic signed [VW-1:0] right_v;
    logic                 left_g;

    if (i == 0) begin : g_head
      assign left_v = '0;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_v = cell_value[i-1];
      assign left_g = ge_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_body
      assign right_v = cell_value[i+1];
    end

    slq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .key         (in_req.item_value),
      .occupied    (fill_r > FILL_W'(i)),
      .at_fill     (fill_r == FILL_W'(i)),
      .left_value  (left_v),
      .left_ge     (left_g),
      .right_value (right_v),
      .value       (cell_value[i]),
      .ge          (ge_vec[i]),
      .eq          (eq_vec[i])
    );

    // largest entry sits in the last occupied cell
    assign tail_pick[i] = (fill_r == FILL_W'(i + 1)) ? cell_value[i] : '0;
  end

  always_comb begin
    tail_value = '0;
    for (int k = 0; k < DEPTH; k++) begin
      tail_value = tail_value | tail_pick[k];
    end
  end

  // request decode
  always_comb begin
    ctl         = '0;
    status_nxt  = slq_pkg::ST_OK;
    removed_nxt = '0;
    fill_nxt    = fill_r;
    case (in_req.req_type)
      slq_pkg::REQ_INSERT: begin
        if (full) begin
          status_nxt = slq_pkg::ST_FULL;
        end else begin
          ctl.insert = accept;
          fill_nxt   = fill_r + 1'b1;
        end
      end
      slq_pkg::REQ_POP_MIN: begin
        if (empty) begin
          status_nxt = slq_pkg::ST_EMPTY;
        end else begin
          ctl.pop_min = accept;
          removed_nxt = cell_value[0];
          fill_nxt    = fill_r - 1'b1;
        end
      end
      slq_pkg::REQ_POP_MAX: begin
        if (empty) begin
          status_nxt = slq_pkg::ST_EMPTY;
        end else begin
          removed_nxt = tail_value;
          fill_nxt    = fill_r - 1'b1;
        end
      end
      slq_pkg::REQ_DEL_MATCH: begin
        if (empty) begin
          status_nxt = slq_pkg::ST_EMPTY;
        end else if (match_any) begin
          ctl.del_match = accept;
          removed_nxt   = in_req.item_value;
          fill_nxt      = fill_r - 1'b1;
        end else begin
          status_nxt = slq_pkg::ST_MISSING;
        end
      end
      slq_pkg::REQ_CLEAR: begin
        fill_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // fill level and response valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r <= fill_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      occ_r     <= slq_pkg::OCC_W'(fill_nxt);
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = status_r;
  assign out_rsp.removed_value = removed_r;
  assign out_rsp.occupancy     = occ_r;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DEPTH))
    else $error("fill level above depth");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && full && (in_req.req_type == slq_pkg::REQ_INSERT)
    |=> $stable(fill_r) && (status_r == slq_pkg::ST_FULL))
    else $error("insert into full queue changed the fill level");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == slq_pkg::ST_EMPTY) |-> (occ_r == '0) && (removed_r == '0))
    else $error("empty response with nonzero occupancy or value");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_req.req_type == slq_pkg::REQ_CLEAR) |=> (fill_r == '0))
    else $error("clear left entries behind");

endmodule

FILE: hdl/slq_cell.sv
// One storage cell of the sorted chain: holds a value and trades with its neighbors.
module slq_cell (
  input  logic                               clk,
  input  slq_pkg::cell_ctl_t                 ctl,
  input  logic signed [slq_pkg::VALUE_W-1:0] key,
  input  logic                               occupied,   // slot lies below the fill level
  input  logic                               at_fill,    // slot is the first free one
  input  logic signed [slq_pkg::VALUE_W-1:0] left_value,
  input  logic                               left_ge,
  input  logic signed [slq_pkg::VALUE_W-1:0] right_value,
  output logic signed [slq_pkg::VALUE_W-1:0] value,
  output logic                               ge,         // occupied and not below key
  output logic                               eq          // occupied and equal to key
);

  logic signed [slq_pkg::VALUE_W-1:0] value_r;
  logic signed [slq_pkg::VALUE_W-1:0] value_nxt;

  // local compares against the broadcast key
  assign ge    = occupied && !(value_r < key);
  assign eq    = occupied && (value_r == key);
  assign value = value_r;

  // pick the next content
  always_comb begin
    value_nxt = value_r;
    if (ctl.insert) begin
      if (left_ge) begin
        value_nxt = left_value;
      end else if (ge || at_fill) begin
        value_nxt = key;
      end
    end else if (ctl.pop_min) begin
      value_nxt = right_value;
    end else if (ctl.del_match && ge) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
